@@ hdl/qirc_pkg.sv @@
`timescale 1ns / 1ps

package qirc_pkg;

	// Field widths
	localparam int unsigned VAL_W   = 16;
	localparam int unsigned ROOT_W  = 16;
	localparam int unsigned BIT_W   = $clog2(ROOT_W);

	// Shared multiplier: wide operand, narrow operand, full product
	localparam int unsigned OPA_W   = 48;
	localparam int unsigned OPB_W   = 16;
	localparam int unsigned PROD_W  = 64;

	// Linear numerators, both before the final scale
	localparam int unsigned LIN_W   = 27;

	localparam logic [VAL_W-1:0] NO_VALUE_DEF = 16'd29999;

	// Scales and offsets
	localparam int unsigned ROOT_SCALE  = 1000;	// RR in ms, roots taken of RR/1000
	localparam int unsigned FRAM_SCALE  = 1000;
	localparam int unsigned FRAM_OFFSET = 154000;
	localparam int unsigned FRAM_RR_K   = 154;
	localparam int unsigned HODG_SCALE  = 4;
	localparam int unsigned HODG_QT_K   = 4;
	localparam int unsigned HODG_HR_K   = 7;
	localparam int unsigned HODG_OFFSET = 420;	// 7 * 60

	typedef enum logic [1:0] {
		M_BAZETT     = 2'd0,
		M_FRIDERICIA = 2'd1,
		M_FRAMINGHAM = 2'd2,
		M_HODGES     = 2'd3
	} method_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_LOAD,
		ST_SMUL,
		ST_SCMP
	} state_t;

	typedef struct packed {
		logic             en;
		logic [OPA_W-1:0] a;
		logic [OPB_W-1:0] b;
	} mul_req_t;

endpackage

@@ hdl/qirc_mul.sv @@
`timescale 1ns / 1ps

// Shared multiplier, product registered.
module qirc_mul (
	input  logic                          clk,
	input  qirc_pkg::mul_req_t            req,
	output logic [qirc_pkg::PROD_W-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= qirc_pkg::PROD_W'(req.a) * qirc_pkg::PROD_W'(req.b);
		end
	end

endmodule

@@ hdl/qirc_seq.sv @@
`timescale 1ns / 1ps

// Sequencer: target set-up, bitwise root / quotient search, result register.
module qirc_seq #(
	parameter logic [qirc_pkg::VAL_W-1:0] NO_VALUE = qirc_pkg::NO_VALUE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  qirc_pkg::method_t             method,
	input  logic [qirc_pkg::VAL_W-1:0]    qt,
	input  logic [qirc_pkg::VAL_W-1:0]    rr,
	input  logic [qirc_pkg::VAL_W-1:0]    hr,
	output logic                          busy,
	output logic                          done,
	output logic [qirc_pkg::VAL_W-1:0]    result,
	output logic                          invalid,
	output qirc_pkg::mul_req_t            mul_req,
	input  logic [qirc_pkg::PROD_W-1:0]   prod
);

	localparam int unsigned VW = qirc_pkg::VAL_W;
	localparam int unsigned LW = qirc_pkg::LIN_W;

	qirc_pkg::state_t state_q, state_d;

	logic [1:0]                       step_q;
	logic [qirc_pkg::BIT_W-1:0]       bit_q;
	logic                             done_q;
	logic [VW-1:0]                    qt_q;
	logic [qirc_pkg::OPB_W-1:0]       scale_q;
	logic [qirc_pkg::PROD_W-1:0]      target_q;
	logic [qirc_pkg::ROOT_W-1:0]      root_q;
	logic [VW-1:0]                    res_q;
	logic                             inv_q;

	logic [1:0]                       pwr;
	logic                             is_root;
	logic                             last_step;
	logic                             accept;
	logic                             in_bad;
	logic                             fits;
	logic [qirc_pkg::ROOT_W-1:0]      trial;
	logic [qirc_pkg::OPB_W-1:0]       x_op;
	logic [qirc_pkg::OPB_W-1:0]       last_op;
	logic [LW-1:0]                    lin_pos;
	logic [LW-1:0]                    lin_neg;
	logic [LW-1:0]                    lin_num;

	// power of the search variable in the compare
	always_comb begin
		unique case (method)
			qirc_pkg::M_BAZETT:     pwr = 2'd2;
			qirc_pkg::M_FRIDERICIA: pwr = 2'd3;
			default:                pwr = 2'd1;
		endcase
	end

	assign is_root   = (method == qirc_pkg::M_BAZETT) || (method == qirc_pkg::M_FRIDERICIA);
	assign last_step = (step_q == pwr - 2'd1);
	assign accept    = start && (state_q == qirc_pkg::ST_IDLE);
	assign in_bad    = (rr == '0) || (rr == NO_VALUE) || (qt == NO_VALUE);
	assign trial     = root_q | (qirc_pkg::ROOT_W'(1) << bit_q);
	assign fits      = (prod <= target_q);

	// linear methods: numerator clamped at zero, scale applied by the search
	always_comb begin
		if (method == qirc_pkg::M_FRAMINGHAM) begin
			lin_pos = LW'(qt) * LW'(qirc_pkg::FRAM_SCALE) + LW'(qirc_pkg::FRAM_OFFSET);
			lin_neg = LW'(rr) * LW'(qirc_pkg::FRAM_RR_K);
		end else begin
			lin_pos = LW'(qt) * LW'(qirc_pkg::HODG_QT_K) + LW'(hr) * LW'(qirc_pkg::HODG_HR_K);
			lin_neg = LW'(qirc_pkg::HODG_OFFSET);
		end
		lin_num = (lin_pos > lin_neg) ? (lin_pos - lin_neg) : '0;
	end

	// pre-phase raises QT, search phase raises the trial root
	assign x_op    = (state_q == qirc_pkg::ST_PRE) ? qt_q : trial;
	assign last_op = (state_q == qirc_pkg::ST_PRE) ? qirc_pkg::OPB_W'(qirc_pkg::ROOT_SCALE)
	                                               : scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qirc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_req = '0;
		unique case (state_q) inside
			qirc_pkg::ST_IDLE: begin
				if (start && !in_bad) begin
					state_d = is_root ? qirc_pkg::ST_PRE : qirc_pkg::ST_SMUL;
				end
			end
			qirc_pkg::ST_PRE, qirc_pkg::ST_SMUL: begin
				mul_req.en = 1'b1;
				if (step_q == 2'd0) begin
					mul_req.a = qirc_pkg::OPA_W'(x_op);
					mul_req.b = (pwr == 2'd1) ? last_op : x_op;
				end else begin
					mul_req.a = prod[qirc_pkg::OPA_W-1:0];
					mul_req.b = last_step ? last_op : x_op;
				end
				if (last_step) begin
					state_d = (state_q == qirc_pkg::ST_PRE) ? qirc_pkg::ST_LOAD
					                                        : qirc_pkg::ST_SCMP;
				end
			end
			qirc_pkg::ST_LOAD: begin
				state_d = qirc_pkg::ST_SMUL;
			end
			qirc_pkg::ST_SCMP: begin
				state_d = (bit_q == '0) ? qirc_pkg::ST_IDLE : qirc_pkg::ST_SMUL;
			end
			default: begin
				state_d = qirc_pkg::ST_IDLE;
			end
		endcase
	end

	// control counters and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			bit_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && in_bad) || ((state_q == qirc_pkg::ST_SCMP) && (bit_q == '0));
			if ((state_q == qirc_pkg::ST_PRE) || (state_q == qirc_pkg::ST_SMUL)) begin
				step_q <= last_step ? 2'd0 : step_q + 2'd1;
			end else begin
				step_q <= 2'd0;
			end
			if (accept) begin
				bit_q <= qirc_pkg::BIT_W'(qirc_pkg::ROOT_W - 1);
			end else if ((state_q == qirc_pkg::ST_SCMP) && (bit_q != '0)) begin
				bit_q <= bit_q - qirc_pkg::BIT_W'(1);
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			qt_q     <= qt;
			scale_q  <= is_root ? rr
			          : (method == qirc_pkg::M_FRAMINGHAM) ? qirc_pkg::OPB_W'(qirc_pkg::FRAM_SCALE)
			          : qirc_pkg::OPB_W'(qirc_pkg::HODG_SCALE);
			target_q <= qirc_pkg::PROD_W'(lin_num);
			root_q   <= '0;
			if (in_bad) begin
				res_q <= NO_VALUE;
				inv_q <= 1'b1;
			end
		end
		if (state_q == qirc_pkg::ST_LOAD) begin
			target_q <= prod;
		end
		if (state_q == qirc_pkg::ST_SCMP) begin
			if (fits) begin
				root_q <= trial;
			end
			if (bit_q == '0) begin
				res_q <= fits ? trial : root_q;
				inv_q <= 1'b0;
			end
		end
	end

	assign busy    = (state_q != qirc_pkg::ST_IDLE);
	assign done    = done_q;
	assign result  = res_q;
	assign invalid = inv_q;

	a_done_idle : assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == qirc_pkg::ST_IDLE))
		else $error("result strobe while sequencer active");

	a_busy_end : assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done_q)
		else $error("search ended without result");

	a_inv_sentinel : assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && inv_q) |-> (res_q == NO_VALUE))
		else $error("invalid result without sentinel");

	a_start_busy : assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_bad) |=> (busy && !done_q))
		else $error("valid item did not start a search");

endmodule

@@ hdl/qt_interval_rate_correction_unit.sv @@
`timescale 1ns / 1ps

// QT interval rate correction.
// Input: pulse start with qt_duration_ms, rr_interval_ms and heart_rate_bpm
// valid; the item is taken at a clock edge where start is high and busy low.
// Output: done is high for exactly one cycle with corrected_qt_ms and
// result_invalid; the receiver cannot hold the result off.
// cfg_we / cfg_wdata write correction_method (0 Bazett, 1 Fridericia,
// 2 Framingham, 3 Hodges); write it only while busy is low.
// busy is low again in the done cycle, so the next item may start there.
// Invalid inputs skip the search. Otherwise each of the 16 steps of the bit
// search makes one to three passes through the shared multiplier and then a
// compare; Bazett and Fridericia first form QT^p*1000 with two or three
// multiplier passes and a load step.
// Reset clears the method to Bazett, the sequencer to idle, done low.
module qt_interval_rate_correction_unit #(
	parameter logic [qirc_pkg::VAL_W-1:0] NO_VALUE = qirc_pkg::NO_VALUE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [qirc_pkg::VAL_W-1:0]    qt_duration_ms,
	input  logic [qirc_pkg::VAL_W-1:0]    rr_interval_ms,
	input  logic [qirc_pkg::VAL_W-1:0]    heart_rate_bpm,
	output logic                          done,
	output logic [qirc_pkg::VAL_W-1:0]    corrected_qt_ms,
	output logic                          result_invalid,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_wdata
);

	qirc_pkg::method_t              method_q;
	qirc_pkg::mul_req_t             mul_req;
	logic [qirc_pkg::PROD_W-1:0]    prod;

	// method register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= qirc_pkg::M_BAZETT;
		end else if (cfg_we) begin
			method_q <= qirc_pkg::method_t'(cfg_wdata);
		end
	end

	// Search is for the largest r with r^p * K <= N:
	//   roots  : N = QT^p * 1000, K = RR (p = 2 or 3)
	//   linear : N = clamped numerator, K = 1000 or 4 (p = 1)
	// r is limited to 16 bits, which gives the saturation at 65535.
	qirc_seq #(
		.NO_VALUE (NO_VALUE)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.method  (method_q),
		.qt      (qt_duration_ms),
		.rr      (rr_interval_ms),
		.hr      (heart_rate_bpm),
		.busy    (busy),
		.done    (done),
		.result  (corrected_qt_ms),
		.invalid (result_invalid),
		.mul_req (mul_req),
		.prod    (prod)
	);

	qirc_mul u_mul (
		.clk    (clk),
		.req    (mul_req),
		.prod_q (prod)
	);

endmodule
